/* design/voxel_label_border_linker_core_macros.svh */
// Assertion macros for the voxel label border linker.
// Used by the top level only; no other dependencies.
`ifndef VOXEL_LABEL_BORDER_LINKER_CORE_MACROS_SVH
`define VOXEL_LABEL_BORDER_LINKER_CORE_MACROS_SVH

// same-cycle implication
`define VLBL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("vlbl assertion failed");

// next-cycle implication
`define VLBL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("vlbl assertion failed");

`endif

/* design/vlbl_pkg.sv */
// Shared constants and the neighbor offset table for the voxel label border linker.
// No dependencies.
package vlbl_pkg;
	localparam int MAX_DIM_DEF = 32;
	localparam int LABEL_MAX   = 15;
	localparam int LBL_W       = 5;
	localparam int MASK_W      = 13;
	localparam int PADDR_W     = 4;
	localparam int NBR_IDX_W   = 4;
	localparam logic [3:0] BUILD_LAST = 4'd6;
	localparam logic [3:0] QUERY_LAST = 4'd13;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_BUILD = 2'd1,
		FN_QUERY = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_DEPTH  = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic       vld;
		logic [3:0] idx;
	} pend_t;

	// {dx,dy,dz}, 2-bit signed each. Index 0 is the voxel itself.
	// Build: 6-neighbors. Query: index k+1 is the forward neighbor with code k+1.
	function automatic logic [5:0] nbr_off(input logic qry, input logic [3:0] idx);
		logic [5:0] r;
		r = 6'b00_00_00;
		if (!qry) begin
			case (idx)
				4'd1: r = 6'b01_00_00;
				4'd2: r = 6'b11_00_00;
				4'd3: r = 6'b00_01_00;
				4'd4: r = 6'b00_11_00;
				4'd5: r = 6'b00_00_01;
				4'd6: r = 6'b00_00_11;
				default: r = 6'b00_00_00;
			endcase
		end else begin
			case (idx)
				4'd1:  r = 6'b00_00_01;
				4'd2:  r = 6'b00_01_11;
				4'd3:  r = 6'b00_01_00;
				4'd4:  r = 6'b00_01_01;
				4'd5:  r = 6'b01_11_11;
				4'd6:  r = 6'b01_11_00;
				4'd7:  r = 6'b01_11_01;
				4'd8:  r = 6'b01_00_11;
				4'd9:  r = 6'b01_00_00;
				4'd10: r = 6'b01_00_01;
				4'd11: r = 6'b01_01_11;
				4'd12: r = 6'b01_01_00;
				4'd13: r = 6'b01_01_01;
				default: r = 6'b00_00_00;
			endcase
		end
		return r;
	endfunction
endpackage

/* design/vlbl_in_if.sv */
// Input channel of the voxel label border linker: valid/ready plus command payload.
// Depends on nothing.
interface vlbl_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [4:0]        pos_x;
	logic [4:0]        pos_y;
	logic [4:0]        pos_z;
	logic signed [4:0] label_in;

	modport source (output valid, func, pos_x, pos_y, pos_z, label_in, input ready);
	modport sink (input valid, func, pos_x, pos_y, pos_z, label_in, output ready);
endinterface

/* design/vlbl_out_if.sv */
// Result channel of the voxel label border linker: valid/ready plus query result.
// Depends on nothing.
interface vlbl_out_if;
	logic              valid;
	logic              ready;
	logic              is_border;
	logic signed [4:0] label_out;
	logic [12:0]       link_mask;
	logic              status;

	modport source (output valid, is_border, label_out, link_mask, status, input ready);
	modport sink (input valid, is_border, label_out, link_mask, status, output ready);
endinterface

/* design/vlbl_nbr.sv */
// Neighbor address generator: offset lookup, range check against the volume, address pack.
// Depends on vlbl_pkg.
module vlbl_nbr #(
	parameter int CW = 5,
	parameter int DW = 6
) (
	input  logic [CW-1:0]   x,
	input  logic [CW-1:0]   y,
	input  logic [CW-1:0]   z,
	input  logic [DW-1:0]   w,
	input  logic [DW-1:0]   h,
	input  logic [DW-1:0]   d,
	input  logic            qry,
	input  logic [3:0]      idx,
	output logic            vld,
	output logic [3*CW-1:0] addr
);
	import vlbl_pkg::*;

	logic [5:0]           off;
	logic signed [CW+1:0] nx, ny, nz;

	always_comb begin
		off = nbr_off(qry, idx);
		nx  = $signed({2'b00, x}) + $signed({{CW{off[5]}}, off[5:4]});
		ny  = $signed({2'b00, y}) + $signed({{CW{off[3]}}, off[3:2]});
		nz  = $signed({2'b00, z}) + $signed({{CW{off[1]}}, off[1:0]});
		vld = !nx[CW+1] && !ny[CW+1] && !nz[CW+1]
			&& (int'(nx) < int'(w)) && (int'(ny) < int'(h)) && (int'(nz) < int'(d));
		addr = {nz[CW-1:0], ny[CW-1:0], nx[CW-1:0]};
	end
endmodule

/* design/voxel_label_border_linker_core.sv */
// Top level of the voxel label border linker: APB registers, sequencer, label and border memories.
// Depends on vlbl_pkg, vlbl_in_if, vlbl_out_if, vlbl_nbr and the macros header.
//
//  channel   dir  kind        beat contents
//  in_ch     in   valid/ready func, pos_x, pos_y, pos_z, label_in
//  out_ch    out  valid/ready is_border, label_out, link_mask, status
//  apb       in   APB write   volume_width/height/depth at 0x0/0x4/0x8
//
// Write: label memory written at the accepting edge.
// Query: 14 single-port reads (voxel plus 13 forward neighbors,
//   label and border memories read side by side), then a drain state and the output load.
//   A query outside the volume skips the reads and goes straight to its output load.
// Build: per voxel, 7 label reads, then a drain state that also writes the
//   border flag; every voxel of the volume is visited in turn.
// Reset (arst_n low) clears control and dims to 32; memories hold garbage, no clear pass.
// A finished query waits in the output register; input is taken while it waits,
//   the next query only stalls at its output load.
`include "voxel_label_border_linker_core_macros.svh"

module voxel_label_border_linker_core #(
	parameter int MAX_DIM = vlbl_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vlbl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	vlbl_in_if.sink                    in_ch,
	vlbl_out_if.source                 out_ch
);
	import vlbl_pkg::*;

	localparam int CW    = $clog2(MAX_DIM);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int AW    = 3 * CW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_DONE} state_t;

	// config registers
	logic [5:0] vol_w_q, vol_h_q, vol_d_q;
	logic       apb_wr;
	reg_idx_t   apb_idx;

	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite;
	assign apb_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_w_q <= 6'd32;
			vol_h_q <= 6'd32;
			vol_d_q <= 6'd32;
		end else if (apb_wr) begin
			case (apb_idx)
				REG_WIDTH:  vol_w_q <= pwdata[5:0];
				REG_HEIGHT: vol_h_q <= pwdata[5:0];
				REG_DEPTH:  vol_d_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (apb_idx)
			REG_WIDTH:  prdata = {26'd0, vol_w_q};
			REG_HEIGHT: prdata = {26'd0, vol_h_q};
			REG_DEPTH:  prdata = {26'd0, vol_d_q};
			default:    prdata = 32'd0;
		endcase
	end

	// zero acts as one, oversize clamps to MAX_DIM
	function automatic logic [DW-1:0] eff_dim(input logic [5:0] r);
		if (r == 6'd0) return DW'(1);
		if (int'(r) > MAX_DIM) return DW'(MAX_DIM);
		return DW'(r);
	endfunction

	logic [DW-1:0] eff_w, eff_h, eff_d;
	logic          in_acc, in_vol;
	func_t         in_func;
	logic [4:0]    lbl_sat;

	assign eff_w   = eff_dim(vol_w_q);
	assign eff_h   = eff_dim(vol_h_q);
	assign eff_d   = eff_dim(vol_d_q);
	assign in_func = func_t'(in_ch.func);
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign in_vol  = (int'(in_ch.pos_x) < int'(eff_w)) && (int'(in_ch.pos_y) < int'(eff_h))
		&& (int'(in_ch.pos_z) < int'(eff_d));

	always_comb begin
		if ((int'(in_ch.label_in) < -1) || (int'(in_ch.label_in) > LABEL_MAX))
			lbl_sat = 5'h1F;
		else
			lbl_sat = in_ch.label_in;
	end

	// sequencer state
	state_t        state_q;
	logic          qry_q, oob_q;
	logic [3:0]    j_q;
	logic [CW-1:0] x_q, y_q, z_q;
	logic [DW-1:0] w_q, h_q, d_q;
	pend_t         pend_s1;
	logic          out_valid_q;
	logic          ob_load;

	// datapath
	logic [4:0]        c_q;
	logic              bc_q, b_q;
	logic [MASK_W-1:0] mask_q;
	logic              ob_border_q, ob_status_q;
	logic [4:0]        ob_label_q;
	logic [MASK_W-1:0] ob_mask_q;

	logic          nbr_vld;
	logic [AW-1:0] nbr_addr;
	logic [3:0]    last_idx;

	vlbl_nbr #(.CW(CW), .DW(DW)) u_nbr (
		.x(x_q), .y(y_q), .z(z_q), .w(w_q), .h(h_q), .d(d_q),
		.qry(qry_q), .idx(j_q), .vld(nbr_vld), .addr(nbr_addr)
	);

	assign last_idx    = qry_q ? QUERY_LAST : BUILD_LAST;
	assign in_ch.ready = (state_q == S_IDLE);
	// output register free or draining this cycle
	assign ob_load     = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// memories: single port, registered read
	logic [4:0]    label_mem [DEPTH];
	logic          border_mem [DEPTH];
	logic          lbl_we, brd_we, brd_wd;
	logic [AW-1:0] lbl_addr, brd_addr, pos_addr;
	logic [4:0]    lbl_rd_q;
	logic          brd_rd_q;

	assign pos_addr = {CW'(in_ch.pos_z), CW'(in_ch.pos_y), CW'(in_ch.pos_x)};
	assign lbl_we   = in_acc && (in_func == FN_WRITE) && in_vol;
	assign lbl_addr = lbl_we ? pos_addr : nbr_addr;
	assign brd_we   = (state_q == S_FIN) && !qry_q;
	assign brd_addr = brd_we ? {z_q, y_q, x_q} : nbr_addr;
	// last neighbor read lands in the drain cycle; fold it in here
	assign brd_wd   = b_q || (pend_s1.vld && (lbl_rd_q != c_q));

	always_ff @(posedge clk) begin
		if (lbl_we) label_mem[lbl_addr] <= lbl_sat;
		else        lbl_rd_q <= label_mem[lbl_addr];
	end

	always_ff @(posedge clk) begin
		if (brd_we) border_mem[brd_addr] <= brd_wd;
		else        brd_rd_q <= border_mem[brd_addr];
	end

	// read-data consume, tracked by pend_s1 behind the issue
	always_ff @(posedge clk) begin
		if (pend_s1.vld) begin
			if (pend_s1.idx == 4'd0) begin
				c_q    <= lbl_rd_q;
				bc_q   <= brd_rd_q;
				b_q    <= 1'b0;
				mask_q <= '0;
			end else if (qry_q) begin
				if (brd_rd_q && (lbl_rd_q == c_q)) mask_q[pend_s1.idx - 4'd1] <= 1'b1;
			end else if (lbl_rd_q != c_q) begin
				b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qry_q       <= 1'b0;
			oob_q       <= 1'b0;
			j_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			w_q         <= DW'(1);
			h_q         <= DW'(1);
			d_q         <= DW'(1);
			pend_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// read issued this cycle is consumed next cycle
			pend_s1.vld <= (state_q == S_RUN) && nbr_vld;
			pend_s1.idx <= j_q;
			if (ob_load)           out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						w_q <= eff_w;
						h_q <= eff_h;
						d_q <= eff_d;
						j_q <= '0;
						case (in_func)
							FN_BUILD: begin
								qry_q   <= 1'b0;
								x_q     <= '0;
								y_q     <= '0;
								z_q     <= '0;
								state_q <= S_RUN;
							end
							FN_QUERY: begin
								qry_q <= 1'b1;
								oob_q <= !in_vol;
								x_q   <= CW'(in_ch.pos_x);
								y_q   <= CW'(in_ch.pos_y);
								z_q   <= CW'(in_ch.pos_z);
								state_q <= in_vol ? S_RUN : S_DONE;
							end
							default: ;
						endcase
					end
				end
				S_RUN: begin
					j_q <= j_q + 4'd1;
					if (j_q == last_idx) state_q <= S_FIN;
				end
				S_FIN: begin
					if (qry_q) begin
						state_q <= S_DONE;
					end else begin
						j_q     <= '0;
						state_q <= ((int'(x_q) == int'(w_q) - 1) && (int'(y_q) == int'(h_q) - 1)
							&& (int'(z_q) == int'(d_q) - 1)) ? S_IDLE : S_RUN;
						if (int'(x_q) == int'(w_q) - 1) begin
							x_q <= '0;
							if (int'(y_q) == int'(h_q) - 1) begin
								y_q <= '0;
								if (int'(z_q) != int'(d_q) - 1) z_q <= z_q + CW'(1);
							end else begin
								y_q <= y_q + CW'(1);
							end
						end else begin
							x_q <= x_q + CW'(1);
						end
					end
				end
				S_DONE: begin
					if (ob_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (ob_load) begin
			ob_status_q <= oob_q;
			ob_border_q <= !oob_q && bc_q;
			ob_label_q  <= oob_q ? 5'd0 : c_q;
			ob_mask_q   <= (!oob_q && bc_q) ? mask_q : '0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.is_border = ob_border_q;
	assign out_ch.label_out = ob_label_q;
	assign out_ch.link_mask = ob_mask_q;
	assign out_ch.status    = ob_status_q;

	// checks
	`VLBL_ASSERT_IMP(a_pend_busy, clk, arst_n, pend_s1.vld, (state_q == S_RUN) || (state_q == S_FIN))
	`VLBL_ASSERT_IMP(a_lbl_wr_idle, clk, arst_n, lbl_we, state_q == S_IDLE)
	`VLBL_ASSERT_IMP(a_run_idx, clk, arst_n, state_q == S_RUN, j_q <= last_idx)
	`VLBL_ASSERT_NXT(a_done_out, clk, arst_n, (state_q == S_DONE) && !out_valid_q, out_valid_q)
endmodule
